// File: rtl/ded_pkg.sv
// shared types and codes for the double-ended queue
package ded_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef logic signed [DATA_W-1:0] t_word;

    // operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_word             push_value;
    } t_in_beat;

    typedef struct packed {
        t_word             popped_value;
        logic [STAT_W-1:0] status;
        t_word             front_value;
        t_word             back_value;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } t_out_beat;

    // command broadcast to every cell, at most one bit set
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } t_cell_cmd;

endpackage

// File: rtl/ded_cell.sv
// one storage cell of the queue row, shifting with its neighbors
module ded_cell
    import ded_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_word     i_push,
    input  t_word     i_left_data,
    input  logic      i_left_valid,
    input  t_word     i_right_data,
    input  logic      i_right_valid,
    output t_word     o_data,
    output logic      o_valid,
    output t_word     o_last_data
);

    t_word r_data;
    t_word n_data;
    logic  r_valid;
    logic  n_valid;

    // next contents from the broadcast command and the neighbors
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_cmd.push_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_cmd.pop_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_cmd.push_back && !r_valid && i_left_valid) begin
            n_data  = i_push;
            n_valid = 1'b1;
        end else if (i_cmd.pop_back && r_valid && !i_right_valid) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    // only the back cell puts its word on the shared back bus
    assign o_last_data = (r_valid && !i_right_valid) ? r_data : '0;

endmodule

// File: rtl/double_ended_queue_unit.sv
// double-ended queue top level: a row of shifting cells, front at cell 0
//
//  channel   valid         stall         payload
//  input     i_in_valid    o_in_stall    i_in_data   (kind, push_value)
//  output    o_out_valid   i_out_stall   o_out_data  (popped, status, front, back, count)
//
// one operation at a time: the cell row updates at the accepting edge and the
// result is formed from the updated row into the output register once that
// register is free; the input stalls while that result is pending and the
// output register is still held. reset empties every cell.
module double_ended_queue_unit
    import ded_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_pend;
    t_word             r_popped;
    logic [STAT_W-1:0] r_status;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              w_in_acc;
    logic              w_full;
    logic              w_empty;
    logic              w_load;
    t_cell_cmd         w_cmd;
    t_word             w_popped;
    logic [STAT_W-1:0] w_status;
    t_word             w_back;

    t_word             w_data      [DEPTH];
    logic              w_valid     [DEPTH];
    t_word             w_last_data [DEPTH];

    assign w_in_acc = i_in_valid && !r_pend;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_load   = r_pend && (!r_out_valid || !i_out_stall);

    // back word bus: at most one cell drives non-zero
    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | w_last_data[i];
        end
    end

    // decode the operation, dropping illegal pushes and pops
    always_comb begin
        w_cmd    = '0;
        w_popped = '0;
        w_status = STAT_OK;
        n_count  = r_count;
        unique case (i_in_data.kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_cmd.push_front = (i_in_data.kind == KIND_PUSH_FRONT);
                    w_cmd.push_back  = (i_in_data.kind == KIND_PUSH_BACK);
                    n_count          = r_count + CNT_W'(1);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                end else begin
                    w_cmd.pop_front = (i_in_data.kind == KIND_POP_FRONT);
                    w_cmd.pop_back  = (i_in_data.kind == KIND_POP_BACK);
                    w_popped = (i_in_data.kind == KIND_POP_FRONT) ? w_data[0] : w_back;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            KIND_QUERY: begin
                w_status = STAT_OK;
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase
        if (!w_in_acc) begin
            w_cmd   = '0;
            n_count = r_count;
        end
    end

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left_d;
        logic  w_left_v;
        t_word w_right_d;
        logic  w_right_v;

        if (g == 0) begin : g_head
            assign w_left_d = i_in_data.push_value;
            assign w_left_v = 1'b1;
        end else begin : g_mid_l
            assign w_left_d = w_data[g-1];
            assign w_left_v = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_d = '0;
            assign w_right_v = 1'b0;
        end else begin : g_mid_r
            assign w_right_d = w_data[g+1];
            assign w_right_v = w_valid[g+1];
        end

        ded_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_push        (i_in_data.push_value),
            .i_left_data   (w_left_d),
            .i_left_valid  (w_left_v),
            .i_right_data  (w_right_d),
            .i_right_valid (w_right_v),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_last_data   (w_last_data[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_acc) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-beat payload held until the row has settled
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_popped <= w_popped;
            r_status <= w_status;
        end
    end

    // output register, built from the updated row
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.popped_value <= r_popped;
            r_out.status       <= r_status;
            r_out.front_value  <= w_valid[0] ? w_data[0] : '0;
            r_out.back_value   <= w_back;
            r_out.occupancy    <= OCC_W'(r_count);
            r_out.is_empty     <= w_empty;
        end
    end

    assign o_in_stall  = r_pend;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
